// File: rtl/xmcr_pkg.sv
package xmcr_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int LEN_W           = 24;
  localparam int TRIES_W         = 8;
  localparam int IDX_W           = 11;
  localparam int CFG_ADDR_W      = 3;
  localparam int CFG_DATA_W      = 32;

  localparam logic [CFG_ADDR_W-1:0] ADDR_MAX_LENGTH  = 3'h0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_START_TRIES = 3'h4;

  localparam logic [LEN_W-1:0]   MAX_LENGTH_RST  = 24'hFFFFFF;
  localparam logic [TRIES_W-1:0] START_TRIES_RST = 8'd10;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_SUB = 8'h1A;
  localparam logic [7:0] CH_C   = 8'h43;

  localparam logic [15:0]      CRC_POLY  = 16'h1021;
  localparam logic [IDX_W-1:0] SHORT_LEN = 11'd128;
  localparam logic [IDX_W-1:0] LONG_LEN  = 11'd1024;

  typedef enum logic [1:0] {
    FUNC_START     = 2'd0,
    FUNC_BYTE      = 2'd1,
    FUNC_TIMEOUT   = 2'd2,
    FUNC_DRAIN_END = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    VERD_NONE   = 2'd0,
    VERD_ACCEPT = 2'd1,
    VERD_DUP    = 2'd2,
    VERD_REJECT = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    STAT_RUN  = 2'd0,
    STAT_DONE = 2'd1,
    STAT_FAIL = 2'd2
  } status_t;

  typedef enum logic [10:0] {
    PH_IDLE   = 11'b000_0000_0001,
    PH_START  = 11'b000_0000_0010,
    PH_HEADER = 11'b000_0000_0100,
    PH_NUM    = 11'b000_0000_1000,
    PH_INV    = 11'b000_0001_0000,
    PH_DATA   = 11'b000_0010_0000,
    PH_CRCH   = 11'b000_0100_0000,
    PH_CRCL   = 11'b000_1000_0000,
    PH_DRAIN  = 11'b001_0000_0000,
    PH_DONE   = 11'b010_0000_0000,
    PH_FAILED = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    logic [LEN_W-1:0]   max_length;
    logic [TRIES_W-1:0] start_tries;
  } cfg_t;

  typedef struct packed {
    logic             tx_valid;
    logic [7:0]       tx_byte;
    logic             data_valid;
    logic [7:0]       data_byte;
    verdict_t         verdict;
    status_t          status;
    logic [LEN_W-1:0] final_length;
  } res_t;

  typedef struct packed {
    res_t res;
    logic twin;
  } qent_t;

  function automatic logic [15:0] crc_step(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic res_t res_tx(input logic [7:0] b, input verdict_t v, input status_t s);
    res_t r;
    r          = '0;
    r.tx_valid = 1'b1;
    r.tx_byte  = b;
    r.verdict  = v;
    r.status   = s;
    return r;
  endfunction

  function automatic res_t res_fail();
    res_t r;
    r        = '0;
    r.status = STAT_FAIL;
    return r;
  endfunction

  function automatic res_t res_data(input logic [7:0] b);
    res_t r;
    r            = '0;
    r.data_valid = 1'b1;
    r.data_byte  = b;
    return r;
  endfunction

  function automatic res_t res_reject();
    res_t r;
    r         = '0;
    r.verdict = VERD_REJECT;
    return r;
  endfunction

  function automatic res_t res_done(input logic [LEN_W-1:0] flen);
    res_t r;
    r              = res_tx(CH_ACK, VERD_NONE, STAT_DONE);
    r.final_length = flen;
    return r;
  endfunction

endpackage

// File: rtl/xmcr_if.sv
interface xmcr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface

interface xmcr_out_if;
  logic        valid;
  logic        ready;
  logic        tx_valid;
  logic [7:0]  tx_byte;
  logic        data_valid;
  logic [7:0]  data_byte;
  logic [1:0]  verdict;
  logic [1:0]  status;
  logic [23:0] final_length;
  logic        last;

  modport source (
    output valid, output tx_valid, output tx_byte, output data_valid, output data_byte,
    output verdict, output status, output final_length, output last, input ready
  );
  modport sink (
    input valid, input tx_valid, input tx_byte, input data_valid, input data_byte,
    input verdict, input status, input final_length, input last, output ready
  );
endinterface

// File: rtl/xmcr_regs.sv
module xmcr_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [xmcr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [xmcr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [xmcr_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                               pready,
  output xmcr_pkg::cfg_t                     cfg
);
  import xmcr_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_length  <= MAX_LENGTH_RST;
      cfg_r.start_tries <= START_TRIES_RST;
    end else if (wr_en) begin
      unique case (paddr)
        ADDR_MAX_LENGTH:  cfg_r.max_length  <= pwdata[LEN_W-1:0];
        ADDR_START_TRIES: cfg_r.start_tries <= pwdata[TRIES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_MAX_LENGTH:  prdata = CFG_DATA_W'(cfg_r.max_length);
      ADDR_START_TRIES: prdata = CFG_DATA_W'(cfg_r.start_tries);
      default:          prdata = '0;
    endcase
  end

endmodule

// File: rtl/xmcr_proto.sv
module xmcr_proto #(
  parameter int COUNT_WIDTH = xmcr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  logic [1:0]           func,
  input  logic [7:0]           rx_byte,
  input  xmcr_pkg::cfg_t       cfg,
  output logic                 push,
  output xmcr_pkg::qent_t      ent
);
  import xmcr_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH + 1 > LEN_W) ? COUNT_WIDTH + 1 : LEN_W;

  phase_t                 phase_r, phase_nxt;
  logic [7:0]             expected_r, expected_nxt;
  logic [7:0]             blk_num_r, blk_num_nxt;
  logic [7:0]             blk_cpl_r, blk_cpl_nxt;
  logic                   long_r, long_nxt;
  logic [IDX_W-1:0]       idx_r, idx_nxt;
  logic [15:0]            crc_r, crc_nxt;
  logic [7:0]             crc_hi_r, crc_hi_nxt;
  logic [TRIES_W-1:0]     tries_r, tries_nxt;
  logic [COUNT_WIDTH-1:0] committed_r, committed_nxt;
  logic [COUNT_WIDTH-1:0] pad_r, pad_nxt;
  logic [IDX_W-1:0]       pad_run_r, pad_run_nxt;

  func_t                  func_e;
  logic [IDX_W-1:0]       len;
  logic                   num_ok;
  logic                   crc_ok;
  logic [CMP_W-1:0]       sum;
  logic                   over;
  logic [COUNT_WIDTH-1:0] flen_cw;
  logic [CMP_W-1:0]       flen_ext;
  logic [LEN_W-1:0]       flen;
  logic                   is_hdr;

  always_comb begin
    func_e   = func_t'(func);
    len      = long_r ? LONG_LEN : SHORT_LEN;
    num_ok   = (~blk_num_r) == blk_cpl_r;
    crc_ok   = crc_r == {crc_hi_r, rx_byte};
    sum      = CMP_W'(committed_r) + CMP_W'(len);
    over     = sum > CMP_W'(cfg.max_length);
    flen_cw  = committed_r - pad_r;
    flen_ext = CMP_W'(flen_cw);
    flen     = flen_ext[LEN_W-1:0];
    is_hdr   = (rx_byte == CH_SOH) || (rx_byte == CH_STX);

    phase_nxt     = phase_r;
    expected_nxt  = expected_r;
    blk_num_nxt   = blk_num_r;
    blk_cpl_nxt   = blk_cpl_r;
    long_nxt      = long_r;
    idx_nxt       = idx_r;
    crc_nxt       = crc_r;
    crc_hi_nxt    = crc_hi_r;
    tries_nxt     = tries_r;
    committed_nxt = committed_r;
    pad_nxt       = pad_r;
    pad_run_nxt   = pad_run_r;
    push          = 1'b0;
    ent.res       = res_fail();
    ent.twin      = 1'b0;

    if (advance) begin
      if (func_e == FUNC_START) begin
        expected_nxt  = 8'd1;
        blk_num_nxt   = '0;
        blk_cpl_nxt   = '0;
        long_nxt      = 1'b0;
        idx_nxt       = '0;
        crc_nxt       = '0;
        crc_hi_nxt    = '0;
        committed_nxt = '0;
        pad_nxt       = '0;
        pad_run_nxt   = '0;
        push          = 1'b1;
        if (cfg.start_tries == '0) begin
          tries_nxt = '0;
          phase_nxt = PH_FAILED;
          ent.res   = res_fail();
        end else begin
          tries_nxt = cfg.start_tries - 1'b1;
          phase_nxt = PH_START;
          ent.res   = res_tx(CH_C, VERD_NONE, STAT_RUN);
        end
      end else begin
        unique case (phase_r)
          PH_START, PH_HEADER: begin
            if (func_e == FUNC_BYTE && is_hdr) begin
              long_nxt    = rx_byte == CH_STX;
              idx_nxt     = '0;
              crc_nxt     = '0;
              pad_run_nxt = '0;
              phase_nxt   = PH_NUM;
            end else if (func_e == FUNC_BYTE && rx_byte == CH_EOT) begin
              phase_nxt = PH_DONE;
              push      = 1'b1;
              ent.res   = res_done(flen);
            end else if (func_e == FUNC_BYTE && rx_byte == CH_CAN) begin
              phase_nxt = PH_FAILED;
              push      = 1'b1;
              ent.res   = res_fail();
            end else if (phase_r == PH_HEADER) begin
              if (func_e == FUNC_TIMEOUT) begin
                phase_nxt = PH_FAILED;
                push      = 1'b1;
                ent.res   = res_fail();
              end else if (func_e == FUNC_BYTE) begin
                phase_nxt = PH_DRAIN;
              end
            end else if (func_e != FUNC_DRAIN_END) begin
              push = 1'b1;
              if (tries_r != '0) begin
                tries_nxt = tries_r - 1'b1;
                ent.res   = res_tx(CH_C, VERD_NONE, STAT_RUN);
              end else begin
                phase_nxt = PH_FAILED;
                ent.res   = res_fail();
              end
            end
          end
          PH_NUM, PH_INV, PH_DATA, PH_CRCH, PH_CRCL: begin
            if (func_e == FUNC_TIMEOUT) begin
              phase_nxt = PH_FAILED;
              push      = 1'b1;
              ent.res   = res_fail();
            end else if (func_e == FUNC_BYTE) begin
              if (phase_r == PH_NUM) begin
                blk_num_nxt = rx_byte;
                phase_nxt   = PH_INV;
              end else if (phase_r == PH_INV) begin
                blk_cpl_nxt = rx_byte;
                phase_nxt   = PH_DATA;
              end else if (phase_r == PH_DATA) begin
                crc_nxt     = crc_step(crc_r, rx_byte);
                pad_run_nxt = (rx_byte == CH_SUB) ? pad_run_r + 1'b1 : '0;
                idx_nxt     = idx_r + 1'b1;
                if (idx_nxt >= len) begin
                  phase_nxt = PH_CRCH;
                end
                push    = 1'b1;
                ent.res = res_data(rx_byte);
              end else if (phase_r == PH_CRCH) begin
                crc_hi_nxt = rx_byte;
                phase_nxt  = PH_CRCL;
              end else begin
                push = 1'b1;
                if (num_ok && blk_num_r == expected_r - 8'd1) begin
                  phase_nxt = PH_HEADER;
                  ent.res   = res_tx(CH_ACK, VERD_DUP, STAT_RUN);
                end else if (num_ok && crc_ok && blk_num_r == expected_r) begin
                  if (over) begin
                    phase_nxt = PH_FAILED;
                    ent.res   = res_tx(CH_CAN, VERD_REJECT, STAT_FAIL);
                    ent.twin  = 1'b1;
                  end else begin
                    committed_nxt = sum[COUNT_WIDTH-1:0];
                    if (pad_run_r == len) begin
                      pad_nxt = pad_r + COUNT_WIDTH'(len);
                    end else begin
                      pad_nxt = COUNT_WIDTH'(pad_run_r);
                    end
                    expected_nxt = expected_r + 8'd1;
                    phase_nxt    = PH_HEADER;
                    ent.res      = res_tx(CH_ACK, VERD_ACCEPT, STAT_RUN);
                  end
                end else begin
                  phase_nxt = PH_DRAIN;
                  ent.res   = res_reject();
                end
              end
            end
          end
          PH_DRAIN: begin
            if (func_e == FUNC_DRAIN_END) begin
              phase_nxt = PH_HEADER;
              push      = 1'b1;
              ent.res   = res_tx(CH_NAK, VERD_NONE, STAT_RUN);
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      expected_r  <= 8'd1;
      blk_num_r   <= '0;
      blk_cpl_r   <= '0;
      long_r      <= 1'b0;
      idx_r       <= '0;
      crc_r       <= '0;
      crc_hi_r    <= '0;
      tries_r     <= '0;
      committed_r <= '0;
      pad_r       <= '0;
      pad_run_r   <= '0;
    end else begin
      phase_r     <= phase_nxt;
      expected_r  <= expected_nxt;
      blk_num_r   <= blk_num_nxt;
      blk_cpl_r   <= blk_cpl_nxt;
      long_r      <= long_nxt;
      idx_r       <= idx_nxt;
      crc_r       <= crc_nxt;
      crc_hi_r    <= crc_hi_nxt;
      tries_r     <= tries_nxt;
      committed_r <= committed_nxt;
      pad_r       <= pad_nxt;
      pad_run_r   <= pad_run_nxt;
    end
  end

endmodule

// File: rtl/xmcr_outq.sv
module xmcr_outq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  xmcr_pkg::qent_t   ent,
  output logic              space,
  xmcr_out_if.source        out_if
);
  import xmcr_pkg::*;

  qent_t      q_r [2];
  logic [1:0] count_r, count_nxt;
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic       half_r;
  qent_t      head;
  res_t       res;
  logic       beat;
  logic       pop;

  assign space = count_r < 2'd2;
  assign head  = q_r[rd_ptr_r];
  assign res   = half_r ? res_tx(CH_CAN, VERD_NONE, STAT_FAIL) : head.res;
  assign beat  = out_if.valid && out_if.ready;
  assign pop   = beat && (!head.twin || half_r);

  assign out_if.valid        = count_r != '0;
  assign out_if.tx_valid     = res.tx_valid;
  assign out_if.tx_byte      = res.tx_byte;
  assign out_if.data_valid   = res.data_valid;
  assign out_if.data_byte    = res.data_byte;
  assign out_if.verdict      = res.verdict;
  assign out_if.status       = res.status;
  assign out_if.final_length = res.final_length;
  assign out_if.last         = !(head.twin && !half_r);

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      half_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
        half_r   <= 1'b0;
      end else if (beat && head.twin) begin
        half_r <= 1'b1;
      end
    end
  end

endmodule

// File: rtl/xmodem_crc_receiver.sv
// XMODEM-CRC / XMODEM-1K receiver. Each input beat carries one event (start, received
// byte, wait timeout, drain end) and yields zero, one or two result beats: control
// bytes to send, tentative payload bytes, block verdicts and transfer status. An event
// is registered on entry, processed combinationally against the protocol state and the
// per-byte CRC-16 step, and its result lands in a two-entry output queue, so one event
// is taken every cycle while the queue has room. A length overflow produces two CAN
// beats from a single queue entry. Registers: max_length at 0x0, start_tries at 0x4;
// the user must see that they are written only while the block is idle; it is not enforced.
module xmodem_crc_receiver #(
  parameter int COUNT_WIDTH = xmcr_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  xmcr_in_if.sink                          in_if,
  xmcr_out_if.source                       out_if,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [xmcr_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [xmcr_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [xmcr_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                             cfg_pready
);
  import xmcr_pkg::*;

  cfg_t       cfg;
  logic       item_valid_r;
  logic [1:0] func_r;
  logic [7:0] byte_r;
  logic       space;
  logic       advance;
  logic       push;
  qent_t      ent;

  assign advance     = item_valid_r && space;
  assign in_if.ready = !item_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      item_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      func_r <= in_if.func;
      byte_r <= in_if.rx_byte;
    end
  end

  xmcr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  xmcr_proto #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_proto (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .func    (func_r),
    .rx_byte (byte_r),
    .cfg     (cfg),
    .push    (push),
    .ent     (ent)
  );

  xmcr_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .ent    (ent),
    .space  (space),
    .out_if (out_if)
  );

endmodule

// File: bench/tb_xmodem_crc_receiver.sv
module tb_xmodem_crc_receiver;
  timeunit 1ns;
  timeprecision 1ps;

  import xmcr_pkg::*;

  localparam int ITEM_TARGET = 1850;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    res_t res;
    logic last;
  } beat_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  xmcr_in_if  in_ch ();
  xmcr_out_if out_ch ();

  xmodem_crc_receiver DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_ch),
    .out_if      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver mirror
  logic [LEN_W-1:0]   max_len_reg = MAX_LENGTH_RST;
  logic [TRIES_W-1:0] tries_reg   = START_TRIES_RST;
  phase_t             rx_phase    = PH_IDLE;
  logic [7:0]         next_blk    = 8'd1;
  logic [7:0]         blk_num     = '0;
  logic [7:0]         blk_inv     = '0;
  logic               blk_long    = 1'b0;
  logic [IDX_W-1:0]   blk_idx     = '0;
  logic [15:0]        blk_crc     = '0;
  logic [7:0]         crc_hi      = '0;
  logic [TRIES_W-1:0] tries_left  = '0;
  logic [LEN_W-1:0]   committed_len = '0;
  logic [LEN_W-1:0]   trail_pad   = '0;
  logic [IDX_W-1:0]   pad_run     = '0;

  beat_t pending[$];

  int mismatches     = 0;
  int counted        = 0;
  int send_idle_pct  = 0;
  int sink_stall_pct = 0;
  int transfers      = 0;
  bit long_sent      = 1'b0;
  int unsigned cycle_count = 0;

  function automatic void log_mismatch(string what, longint want, longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
  endfunction

  function automatic logic [15:0] crc16_update(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int k = 7; k >= 0; k--) begin
      fb = c[15] ^ b[k];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic res_t make_result(input logic txv, input logic [7:0] txb, input logic dv,
                                       input logic [7:0] db, input verdict_t v,
                                       input status_t s, input logic [LEN_W-1:0] fl);
    res_t r;
    r.tx_valid     = txv;
    r.tx_byte      = txb;
    r.data_valid   = dv;
    r.data_byte    = db;
    r.verdict      = v;
    r.status       = s;
    r.final_length = fl;
    return r;
  endfunction

  function automatic res_t fail_result();
    rx_phase = PH_FAILED;
    return make_result(1'b0, 8'h00, 1'b0, 8'h00, VERD_NONE, STAT_FAIL, '0);
  endfunction

  function automatic res_t done_result();
    rx_phase = PH_DONE;
    return make_result(1'b1, CH_ACK, 1'b0, 8'h00, VERD_NONE, STAT_DONE,
                       committed_len - trail_pad);
  endfunction

  function automatic void open_block(input logic [7:0] b);
    blk_long = (b == CH_STX);
    blk_idx  = '0;
    blk_crc  = '0;
    pad_run  = '0;
    rx_phase = PH_NUM;
  endfunction

  task automatic predict_event(input func_t f, input logic [7:0] b, output bit ignored);
    res_t             beats[$];
    logic [IDX_W-1:0] blen;
    logic [LEN_W:0]   grown;
    logic             num_ok;
    logic             crc_ok;
    beat_t            nb;
    ignored = 1'b0;
    blen = blk_long ? LONG_LEN : SHORT_LEN;
    if (f == FUNC_START) begin
      next_blk      = 8'd1;
      blk_num       = '0;
      blk_inv       = '0;
      blk_long      = 1'b0;
      blk_idx       = '0;
      blk_crc       = '0;
      crc_hi        = '0;
      committed_len = '0;
      trail_pad     = '0;
      pad_run       = '0;
      if (tries_reg == 0) begin
        tries_left = '0;
        beats.insert(beats.size(), fail_result());
      end else begin
        tries_left = tries_reg - 1'b1;
        rx_phase   = PH_START;
        beats.insert(beats.size(),
                     make_result(1'b1, CH_C, 1'b0, 8'h00, VERD_NONE, STAT_RUN, '0));
      end
    end else begin
      case (rx_phase)
        PH_START: begin
          if (f == FUNC_DRAIN_END) begin
            ignored = 1'b1;
          end else if (f == FUNC_BYTE && (b == CH_SOH || b == CH_STX)) begin
            open_block(b);
          end else if (f == FUNC_BYTE && b == CH_EOT) begin
            beats.insert(beats.size(), done_result());
          end else if (f == FUNC_BYTE && b == CH_CAN) begin
            beats.insert(beats.size(), fail_result());
          end else if (tries_left != 0) begin
            tries_left = tries_left - 1'b1;
            beats.insert(beats.size(),
                         make_result(1'b1, CH_C, 1'b0, 8'h00, VERD_NONE, STAT_RUN, '0));
          end else begin
            beats.insert(beats.size(), fail_result());
          end
        end
        PH_HEADER: begin
          if (f == FUNC_TIMEOUT) begin
            beats.insert(beats.size(), fail_result());
          end else if (f == FUNC_DRAIN_END) begin
            ignored = 1'b1;
          end else if (b == CH_SOH || b == CH_STX) begin
            open_block(b);
          end else if (b == CH_EOT) begin
            beats.insert(beats.size(), done_result());
          end else if (b == CH_CAN) begin
            beats.insert(beats.size(), fail_result());
          end else begin
            rx_phase = PH_DRAIN;
          end
        end
        PH_NUM, PH_INV, PH_DATA, PH_CRCH, PH_CRCL: begin
          if (f == FUNC_TIMEOUT) begin
            beats.insert(beats.size(), fail_result());
          end else if (f == FUNC_DRAIN_END) begin
            ignored = 1'b1;
          end else if (rx_phase == PH_NUM) begin
            blk_num  = b;
            rx_phase = PH_INV;
          end else if (rx_phase == PH_INV) begin
            blk_inv  = b;
            rx_phase = PH_DATA;
          end else if (rx_phase == PH_DATA) begin
            blk_crc = crc16_update(blk_crc, b);
            pad_run = (b == CH_SUB) ? pad_run + 1'b1 : '0;
            blk_idx = blk_idx + 1'b1;
            if (blk_idx >= blen)
              rx_phase = PH_CRCH;
            beats.insert(beats.size(),
                         make_result(1'b0, 8'h00, 1'b1, b, VERD_NONE, STAT_RUN, '0));
          end else if (rx_phase == PH_CRCH) begin
            crc_hi   = b;
            rx_phase = PH_CRCL;
          end else begin
            num_ok = (~blk_num) == blk_inv;
            crc_ok = blk_crc == {crc_hi, b};
            if (num_ok && blk_num == next_blk - 8'd1) begin
              rx_phase = PH_HEADER;
              beats.insert(beats.size(),
                           make_result(1'b1, CH_ACK, 1'b0, 8'h00, VERD_DUP, STAT_RUN, '0));
            end else if (num_ok && crc_ok && blk_num == next_blk) begin
              grown = {1'b0, committed_len} + blen;
              if (grown > {1'b0, max_len_reg}) begin
                rx_phase = PH_FAILED;
                beats.insert(beats.size(), make_result(1'b1, CH_CAN, 1'b0, 8'h00,
                                                       VERD_REJECT, STAT_FAIL, '0));
                beats.insert(beats.size(), make_result(1'b1, CH_CAN, 1'b0, 8'h00,
                                                       VERD_NONE, STAT_FAIL, '0));
              end else begin
                committed_len = grown[LEN_W-1:0];
                trail_pad = (pad_run == blen) ? trail_pad + blen : LEN_W'(pad_run);
                next_blk  = next_blk + 8'd1;
                rx_phase  = PH_HEADER;
                beats.insert(beats.size(), make_result(1'b1, CH_ACK, 1'b0, 8'h00,
                                                       VERD_ACCEPT, STAT_RUN, '0));
              end
            end else begin
              rx_phase = PH_DRAIN;
              beats.insert(beats.size(), make_result(1'b0, 8'h00, 1'b0, 8'h00,
                                                     VERD_REJECT, STAT_RUN, '0));
            end
          end
        end
        PH_DRAIN: begin
          if (f == FUNC_DRAIN_END) begin
            rx_phase = PH_HEADER;
            beats.insert(beats.size(),
                         make_result(1'b1, CH_NAK, 1'b0, 8'h00, VERD_NONE, STAT_RUN, '0));
          end else begin
            ignored = 1'b1;
          end
        end
        default: ignored = 1'b1;
      endcase
    end
    foreach (beats[i]) begin
      nb.res  = beats[i];
      nb.last = (i == beats.size() - 1);
      pending.insert(pending.size(), nb);
    end
  endtask

  task automatic send_event(input func_t f, input logic [7:0] b);
    bit ignored;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.func    <= f;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    predict_event(f, b, ignored);
    if (!ignored)
      counted++;
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_register(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] want);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (cfg_prdata !== want)
      log_mismatch("register read", want, cfg_prdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_register(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    if (addr == ADDR_MAX_LENGTH)
      max_len_reg = value[LEN_W-1:0];
    else
      tries_reg = value[TRIES_W-1:0];
    check_register(addr, (addr == ADDR_MAX_LENGTH) ? {8'h00, max_len_reg} : {24'h0, tries_reg});
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_SOH || b == CH_STX || b == CH_EOT || b == CH_CAN);
    return b;
  endfunction

  task automatic drain_out();
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(1) == 0)
        send_event(FUNC_BYTE, 8'($urandom));
      else
        send_event(FUNC_TIMEOUT, 8'($urandom));
    end
    send_event(FUNC_DRAIN_END, 8'($urandom));
  endtask

  task automatic send_block(input bit long_form);
    logic [7:0]  num;
    logic [7:0]  inv;
    logic [7:0]  b;
    logic [15:0] crc;
    int          kind;
    int          len;
    int          pad_len;
    int          cut_at;
    kind   = $urandom_range(99);
    len    = long_form ? 1024 : 128;
    cut_at = (kind >= 94) ? $urandom_range(len - 1) : len;
    num    = next_blk;
    if (kind >= 55 && kind < 70)
      num = next_blk - 8'd1;
    else if (kind >= 70 && kind < 78)
      num = next_blk + 8'($urandom_range(1, 253));
    inv = ~num;
    if (kind >= 78 && kind < 86)
      inv = inv ^ 8'($urandom_range(1, 255));
    case ($urandom_range(4))
      0, 1: pad_len = 0;
      2, 3: pad_len = $urandom_range(1, len);
      default: pad_len = len;
    endcase
    send_event(FUNC_BYTE, long_form ? CH_STX : CH_SOH);
    send_event(FUNC_BYTE, num);
    send_event(FUNC_BYTE, inv);
    crc = '0;
    for (int i = 0; i < len; i++) begin
      if (i == cut_at) begin
        send_event(($urandom_range(1) == 0) ? FUNC_TIMEOUT : FUNC_START, 8'($urandom));
        return;
      end
      if (i >= len - pad_len || $urandom_range(7) == 0)
        b = CH_SUB;
      else
        b = 8'($urandom);
      crc = crc16_update(crc, b);
      send_event(FUNC_BYTE, b);
    end
    if (kind >= 86 && kind < 94)
      crc = crc ^ (16'h0001 << $urandom_range(15));
    send_event(FUNC_BYTE, crc[15:8]);
    send_event(FUNC_BYTE, crc[7:0]);
  endtask

  task automatic run_transfer();
    int  blocks;
    int  choice;
    bit  long_form;
    if (transfers == 0 || $urandom_range(2) == 0) begin
      settle();
      case ($urandom_range(5))
        0: set_register(ADDR_MAX_LENGTH, 32'd0);
        1: set_register(ADDR_MAX_LENGTH, 32'd128 * $urandom_range(1, 3));
        2: set_register(ADDR_MAX_LENGTH, {8'h00, 24'hFFFFFF});
        default: set_register(ADDR_MAX_LENGTH, {8'h00, 24'($urandom)});
      endcase
      case ($urandom_range(11))
        0: set_register(ADDR_START_TRIES, 32'd0);
        1, 2: set_register(ADDR_START_TRIES, 32'd255);
        3, 4, 5, 6: set_register(ADDR_START_TRIES, 32'($urandom_range(1, 3)));
        default: set_register(ADDR_START_TRIES, 32'($urandom_range(1, 255)));
      endcase
    end
    transfers++;
    send_event(FUNC_START, 8'($urandom));
    repeat ($urandom_range(0, 2)) begin
      if (rx_phase == PH_START) begin
        case ($urandom_range(2))
          0: send_event(FUNC_BYTE, noise_byte());
          1: send_event(FUNC_TIMEOUT, 8'($urandom));
          default: send_event(FUNC_DRAIN_END, 8'($urandom));
        endcase
      end
    end
    blocks = $urandom_range(1, 4);
    while (blocks > 0 && (rx_phase == PH_START || rx_phase == PH_HEADER)) begin
      if (rx_phase == PH_HEADER && $urandom_range(5) == 0) begin
        send_event(FUNC_BYTE, noise_byte());
        drain_out();
      end
      long_form = (!long_sent && transfers >= 3) || $urandom_range(19) == 0;
      if (long_form)
        long_sent = 1'b1;
      send_block(long_form);
      if (rx_phase == PH_DRAIN)
        drain_out();
      blocks--;
    end
    if (rx_phase == PH_START || rx_phase == PH_HEADER) begin
      choice = $urandom_range(9);
      if (choice < 7)
        send_event(FUNC_BYTE, CH_EOT);
      else if (choice == 7)
        send_event(FUNC_BYTE, CH_CAN);
      else if (choice == 8)
        send_event(FUNC_TIMEOUT, 8'($urandom));
    end
    if ((rx_phase == PH_DONE || rx_phase == PH_FAILED) && $urandom_range(3) == 0)
      send_event(func_t'($urandom_range(1, 3)), 8'($urandom));
  endtask

  task automatic test_register_access();
    check_register(ADDR_MAX_LENGTH, {8'h00, MAX_LENGTH_RST});
    check_register(ADDR_START_TRIES, {24'h0, START_TRIES_RST});
    set_register(ADDR_MAX_LENGTH, 32'd0);
    set_register(ADDR_MAX_LENGTH, {8'h00, 24'hFFFFFF});
    set_register(ADDR_START_TRIES, 32'd255);
    set_register(ADDR_START_TRIES, 32'd0);
    set_register(ADDR_START_TRIES, {24'h0, START_TRIES_RST});
  endtask

  task automatic test_event_corners();
    send_event(FUNC_TIMEOUT, 8'h00);
    send_event(FUNC_BYTE, 8'hFF);
    send_event(FUNC_DRAIN_END, 8'hA5);
    settle();
    set_register(ADDR_START_TRIES, 32'd0);
    send_event(FUNC_START, 8'h00);
    send_event(FUNC_TIMEOUT, 8'h00);
    settle();
    set_register(ADDR_START_TRIES, 32'd2);
    send_event(FUNC_START, 8'hFF);
    send_event(FUNC_BYTE, 8'h55);
    send_event(FUNC_TIMEOUT, 8'h00);
    send_event(FUNC_START, 8'h00);
    send_event(FUNC_DRAIN_END, 8'h00);
    send_event(FUNC_TIMEOUT, 8'h00);
    send_event(FUNC_BYTE, CH_CAN);
    send_event(FUNC_START, 8'h00);
    send_event(FUNC_BYTE, CH_EOT);
    send_event(FUNC_BYTE, CH_SOH);
    send_event(FUNC_START, 8'h00);
    send_event(FUNC_BYTE, CH_STX);
    send_event(FUNC_BYTE, 8'h01);
    send_event(FUNC_START, 8'h00);
    send_event(FUNC_BYTE, CH_SOH);
    send_event(FUNC_BYTE, 8'h01);
    send_event(FUNC_BYTE, 8'hFE);
    send_event(FUNC_BYTE, 8'h00);
    send_event(FUNC_TIMEOUT, 8'h00);
  endtask

  task automatic test_random_transfers();
    counted = 0;
    while (counted < ITEM_TARGET) begin
      case (counted * 4 / ITEM_TARGET)
        0: begin
          send_idle_pct  = 0;
          sink_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 57;
          sink_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          sink_stall_pct = 57;
        end
        default: begin
          send_idle_pct  = 17;
          sink_stall_pct = 17;
        end
      endcase
      run_transfer();
    end
  endtask

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    beat_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending.size() == 0) begin
        log_mismatch("beat with nothing pending", 0, 1);
      end else begin
        want = pending.pop_front();
        if (out_ch.tx_valid !== want.res.tx_valid)
          log_mismatch("tx_valid", want.res.tx_valid, out_ch.tx_valid);
        if (out_ch.tx_byte !== want.res.tx_byte)
          log_mismatch("tx_byte", want.res.tx_byte, out_ch.tx_byte);
        if (out_ch.data_valid !== want.res.data_valid)
          log_mismatch("data_valid", want.res.data_valid, out_ch.data_valid);
        if (out_ch.data_byte !== want.res.data_byte)
          log_mismatch("data_byte", want.res.data_byte, out_ch.data_byte);
        if (out_ch.verdict !== want.res.verdict)
          log_mismatch("verdict", want.res.verdict, out_ch.verdict);
        if (out_ch.status !== want.res.status)
          log_mismatch("status", want.res.status, out_ch.status);
        if (out_ch.final_length !== want.res.final_length)
          log_mismatch("final_length", want.res.final_length, out_ch.final_length);
        if (out_ch.last !== want.last)
          log_mismatch("last", want.last, out_ch.last);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.func    <= FUNC_START;
    in_ch.rx_byte <= 8'h00;
    cfg_psel      <= 1'b0;
    cfg_penable   <= 1'b0;
    cfg_pwrite    <= 1'b0;
    cfg_paddr     <= '0;
    cfg_pwdata    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_register_access();
    test_event_corners();
    test_random_transfers();
    settle();
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/xmcr_pkg.sv
rtl/xmcr_if.sv
rtl/xmcr_regs.sv
rtl/xmcr_proto.sv
rtl/xmcr_outq.sv
rtl/xmodem_crc_receiver.sv
bench/tb_xmodem_crc_receiver.sv
